// ----- src/spi_pkg.sv -----
package spi_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int FIX_BITS   = 32;
    localparam int QDEPTH     = 4;

    // Exact widths of the line equation terms
    localparam int DIFW = COORD_BITS + 1;
    localparam int CW   = 2 * COORD_BITS + 2;
    localparam int DETW = 2 * COORD_BITS + 3;
    localparam int PRW  = CW + DIFW;
    localparam int DXW  = PRW + 1;
    localparam int NW   = DXW + FRAC_BITS;
    localparam int QW   = NW + 1;

    localparam logic [1:0] STAT_NONE    = 2'd0;
    localparam logic [1:0] STAT_CROSS   = 2'd1;
    localparam logic [1:0] STAT_OVERLAP = 2'd2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [FIX_BITS-1:0]   t_fix;
    typedef logic signed [DIFW-1:0]       t_diff;
    typedef logic signed [CW-1:0]         t_cval;
    typedef logic signed [DETW-1:0]       t_det;
    typedef logic signed [PRW-1:0]        t_prod;
    typedef logic signed [DXW-1:0]        t_dx;
    typedef logic signed [NW-1:0]         t_num;
    typedef logic signed [QW-1:0]         t_q;
    typedef logic [DETW+NW-1:0]           t_aq;

    typedef struct packed {
        t_coord first_start_x;
        t_coord first_start_y;
        t_coord first_end_x;
        t_coord first_end_y;
        t_coord second_start_x;
        t_coord second_start_y;
        t_coord second_end_x;
        t_coord second_end_y;
    } t_seg_pair;

    typedef struct packed {
        logic [1:0] status;
        t_fix       cross_x;
        t_fix       cross_y;
        t_coord     overlap_start_x;
        t_coord     overlap_start_y;
        t_coord     overlap_end_x;
        t_coord     overlap_end_y;
    } t_result;

    typedef struct packed {
        logic      is_cross;
        t_diff     a1;
        t_diff     b1;
        t_diff     a2;
        t_diff     b2;
        t_cval     c1;
        t_cval     c2;
        t_det      det;
        t_seg_pair pts;
        t_result   rslt;
    } t_job;

    typedef struct packed {
        logic      is_cross;
        logic      neg_x;
        logic      neg_y;
        t_seg_pair pts;
        t_result   rslt;
    } t_side;

endpackage

// ----- src/spi_if.sv -----
interface spi_in_if import spi_pkg::*; ();
    logic      valid;
    logic      ready;
    t_seg_pair data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spi_out_if import spi_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/segment_pair_intersection.sv -----
// From accept to result an item passes three front stages, the queue, three back stages
// ahead of the divider, one division step per quotient bit, then sign and output registers.
// Throughput: one item per cycle unless the output stalls; the divider sets most latency.
// The four-entry queue lets the front keep accepting while the output is stalled.
// Reset (synchronous, active low) empties the pipelines and the queue; no other state.
module segment_pair_intersection import spi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spi_in_if.sink    i_seg,
    spi_out_if.source o_res
);

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_job w_job_in;
    t_job w_job_out;

    spi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (i_seg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    spi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_empty (w_empty)
    );

    spi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_job_out),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.status == STAT_NONE ||
                         o_res.data.status == STAT_CROSS ||
                         o_res.data.status == STAT_OVERLAP))
        else $error("undefined status code");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.status == STAT_NONE) |->
            (o_res.data.cross_x == '0 && o_res.data.cross_y == '0 &&
             o_res.data.overlap_start_x == '0 && o_res.data.overlap_end_x == '0))
        else $error("fields set on a result with no intersection");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_empty |-> !w_pop)
        else $error("queue popped while empty");

endmodule

// ----- src/spi_front.sv -----
module spi_front import spi_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    spi_in_if.sink i_seg,
    input  logic   i_full,
    output logic   o_push,
    output t_job   o_job
);

    logic      w_en;
    logic      r_f1_v;
    t_seg_pair r_f1_p;

    t_coord p0, p1, p2, p3, p4, p5, p6, p7;
    t_diff  w_d20, w_d31, w_d64, w_d75, w_b1, w_b2;
    t_diff  w_d51, w_d71, w_d40, w_d60, w_d15, w_d04;

    t_coord     w_px [4];
    t_coord     w_py [4];
    logic [1:0] w_rank [4];
    logic [1:0] w_ord [4];
    logic       w_lt;
    t_result    n_ovl;

    logic      r_f2_v;
    t_seg_pair r_f2_pts;
    t_diff     r_a1, r_b1, r_a2, r_b2;
    t_det      r_mc1a, r_mc1b, r_mc2a, r_mc2b, r_md1, r_md2;
    t_det      r_x1a, r_x1b, r_x2a, r_x2b, r_x3a, r_x3b;
    t_result   r_f2_ovl;

    t_det  w_det;
    logic  w_coll;
    t_job  n_job;
    logic  r_f3_v;
    t_job  r_f3_job;

    function automatic t_coord pick_x(t_seg_pair p, logic [1:0] k);
        t_coord v;
        unique case (k)
            2'd0: v = p.first_start_x;
            2'd1: v = p.first_end_x;
            2'd2: v = p.second_start_x;
            default: v = p.second_end_x;
        endcase
        return v;
    endfunction

    function automatic t_coord pick_y(t_seg_pair p, logic [1:0] k);
        t_coord v;
        unique case (k)
            2'd0: v = p.first_start_y;
            2'd1: v = p.first_end_y;
            2'd2: v = p.second_start_y;
            default: v = p.second_end_y;
        endcase
        return v;
    endfunction

    // Stall the whole front only while the last stage holds an item the queue cannot take
    assign w_en        = !r_f3_v || !i_full;
    assign i_seg.ready = w_en;
    assign o_push      = r_f3_v && !i_full;
    assign o_job       = r_f3_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
        end else if (w_en) begin
            r_f1_v <= i_seg.valid;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_p <= i_seg.data;
        end
    end

    assign p0 = r_f1_p.first_start_x;
    assign p1 = r_f1_p.first_start_y;
    assign p2 = r_f1_p.first_end_x;
    assign p3 = r_f1_p.first_end_y;
    assign p4 = r_f1_p.second_start_x;
    assign p5 = r_f1_p.second_start_y;
    assign p6 = r_f1_p.second_end_x;
    assign p7 = r_f1_p.second_end_y;

    assign w_d20 = t_diff'(p2) - t_diff'(p0);
    assign w_d31 = t_diff'(p3) - t_diff'(p1);
    assign w_d64 = t_diff'(p6) - t_diff'(p4);
    assign w_d75 = t_diff'(p7) - t_diff'(p5);
    assign w_b1  = t_diff'(p0) - t_diff'(p2);
    assign w_b2  = t_diff'(p4) - t_diff'(p6);
    assign w_d51 = t_diff'(p5) - t_diff'(p1);
    assign w_d71 = t_diff'(p7) - t_diff'(p1);
    assign w_d40 = t_diff'(p4) - t_diff'(p0);
    assign w_d60 = t_diff'(p6) - t_diff'(p0);
    assign w_d15 = t_diff'(p1) - t_diff'(p5);
    assign w_d04 = t_diff'(p0) - t_diff'(p4);

    // Rank the four endpoints by x, then y, then input order
    always_comb begin
        w_px[0] = p0; w_py[0] = p1;
        w_px[1] = p2; w_py[1] = p3;
        w_px[2] = p4; w_py[2] = p5;
        w_px[3] = p6; w_py[3] = p7;
        w_lt = 1'b0;
        for (int i = 0; i < 4; i++) begin
            w_rank[i] = 2'd0;
            for (int j = 0; j < 4; j++) begin
                if (i != j) begin
                    w_lt = (w_px[j] < w_px[i]) ||
                           ((w_px[j] == w_px[i]) &&
                            ((w_py[j] < w_py[i]) || ((w_py[j] == w_py[i]) && (j < i))));
                    w_rank[i] = w_rank[i] + 2'(w_lt);
                end
            end
        end
        for (int k = 0; k < 4; k++) begin
            w_ord[k] = 2'd0;
            for (int i = 0; i < 4; i++) begin
                if (w_rank[i] == 2'(k)) begin
                    w_ord[k] = 2'(i);
                end
            end
        end
        n_ovl = '0;
        if (w_ord[0][1] != w_ord[1][1]) begin
            n_ovl.status          = STAT_OVERLAP;
            n_ovl.overlap_start_x = pick_x(r_f1_p, w_ord[1]);
            n_ovl.overlap_start_y = pick_y(r_f1_p, w_ord[1]);
            n_ovl.overlap_end_x   = pick_x(r_f1_p, w_ord[2]);
            n_ovl.overlap_end_y   = pick_y(r_f1_p, w_ord[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f2_pts <= r_f1_p;
            r_a1     <= w_d31;
            r_b1     <= w_b1;
            r_a2     <= w_d75;
            r_b2     <= w_b2;
            r_mc1a   <= t_det'(p1) * t_det'(w_d20);
            r_mc1b   <= t_det'(p0) * t_det'(w_d31);
            r_mc2a   <= t_det'(p5) * t_det'(w_d64);
            r_mc2b   <= t_det'(p4) * t_det'(w_d75);
            r_md1    <= t_det'(w_d31) * t_det'(w_b2);
            r_md2    <= t_det'(w_d75) * t_det'(w_b1);
            r_x1a    <= t_det'(w_d20) * t_det'(w_d51);
            r_x1b    <= t_det'(w_d31) * t_det'(w_d40);
            r_x2a    <= t_det'(w_d20) * t_det'(w_d71);
            r_x2b    <= t_det'(w_d31) * t_det'(w_d60);
            r_x3a    <= t_det'(w_d64) * t_det'(w_d15);
            r_x3b    <= t_det'(w_d75) * t_det'(w_d04);
            r_f2_ovl <= n_ovl;
        end
    end

    assign w_det  = r_md1 - r_md2;
    assign w_coll = (r_x1a == r_x1b) && (r_x2a == r_x2b) && (r_x3a == r_x3b);

    always_comb begin
        n_job          = '0;
        n_job.is_cross = (w_det != '0);
        n_job.a1       = r_a1;
        n_job.b1       = r_b1;
        n_job.a2       = r_a2;
        n_job.b2       = r_b2;
        n_job.c1       = t_cval'(r_mc1a - r_mc1b);
        n_job.c2       = t_cval'(r_mc2a - r_mc2b);
        n_job.det      = w_det;
        n_job.pts      = r_f2_pts;
        if ((w_det == '0) && w_coll) begin
            n_job.rslt = r_f2_ovl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f3_job <= n_job;
        end
    end

endmodule

// ----- src/spi_fifo.sv -----
module spi_fifo import spi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    localparam int AW = $clog2(QDEPTH);

    t_job          r_mem [QDEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- src/spi_back.sv -----
module spi_back import spi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_job,
    output logic       o_pop,
    spi_out_if.source  o_res
);

    logic w_en;

    logic  r_b1_v;
    t_prod r_m0, r_m1, r_m2, r_m3;
    t_det  r_b1_det;
    t_side r_b1_side;

    logic  r_b2_v;
    t_dx   r_dx, r_dy;
    t_det  r_b2_det;
    t_side r_b2_side;

    t_num            w_sx, w_sy;
    logic            r_b3_v;
    logic [NW-1:0]   r_magx, r_magy;
    logic [DETW-1:0] r_dmag;
    t_side           r_b3_side;

    logic            r_dv_v [NW];
    t_aq             r_aqx [NW];
    t_aq             r_aqy [NW];
    logic [DETW-1:0] r_dd [NW];
    t_side           r_ds [NW];

    logic  r_s_v;
    t_q    r_qx, r_qy;
    t_side r_s_side;

    logic    r_o_v;
    t_result r_o;
    t_result n_o;
    logic    w_on1, w_on2;

    // One restoring division step: shift in the next dividend bit, subtract if it fits
    function automatic t_aq div_step(t_aq aq, logic [DETW-1:0] d);
        logic [DETW:0] a_s;
        logic [NW-1:0] q_s;
        a_s = aq[DETW+NW-1:NW-1];
        q_s = {aq[NW-2:0], 1'b0};
        if (a_s >= {1'b0, d}) begin
            a_s    = a_s - {1'b0, d};
            q_s[0] = 1'b1;
        end
        return {a_s[DETW-1:0], q_s};
    endfunction

    function automatic logic on_seg(t_q qx, t_q qy, t_coord sx, t_coord sy,
                                    t_coord ex, t_coord ey);
        logic vert;
        t_q   v, l1, l2;
        vert = (sx == ex);
        v    = vert ? qy : qx;
        l1   = t_q'(vert ? sy : sx) <<< FRAC_BITS;
        l2   = t_q'(vert ? ey : ex) <<< FRAC_BITS;
        return ((l1 <= v) && (v <= l2)) || ((l2 <= v) && (v <= l1));
    endfunction

    // Advance the whole back pipeline together; the output register parts it from the sink
    assign w_en  = !r_o_v || o_res.ready;
    assign o_pop = w_en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
            r_s_v  <= 1'b0;
            r_o_v  <= 1'b0;
        end else if (w_en) begin
            r_b1_v <= !i_empty;
            r_b2_v <= r_b1_v;
            r_b3_v <= r_b2_v;
            r_s_v  <= r_dv_v[NW-1];
            r_o_v  <= r_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m0               <= t_prod'(i_job.c2) * t_prod'(i_job.b1);
            r_m1               <= t_prod'(i_job.c1) * t_prod'(i_job.b2);
            r_m2               <= t_prod'(i_job.a2) * t_prod'(i_job.c1);
            r_m3               <= t_prod'(i_job.a1) * t_prod'(i_job.c2);
            r_b1_det           <= i_job.det;
            r_b1_side.is_cross <= i_job.is_cross;
            r_b1_side.neg_x    <= 1'b0;
            r_b1_side.neg_y    <= 1'b0;
            r_b1_side.pts      <= i_job.pts;
            r_b1_side.rslt     <= i_job.rslt;

            r_dx      <= t_dx'(r_m0) - t_dx'(r_m1);
            r_dy      <= t_dx'(r_m2) - t_dx'(r_m3);
            r_b2_det  <= r_b1_det;
            r_b2_side <= r_b1_side;
        end
    end

    assign w_sx = t_num'(r_dx) <<< FRAC_BITS;
    assign w_sy = t_num'(r_dy) <<< FRAC_BITS;

    // Divide magnitudes; keep the quotient signs aside
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_magx             <= w_sx[NW-1] ? -w_sx : w_sx;
            r_magy             <= w_sy[NW-1] ? -w_sy : w_sy;
            r_dmag             <= r_b2_det[DETW-1] ? -r_b2_det : r_b2_det;
            r_b3_side.is_cross <= r_b2_side.is_cross;
            r_b3_side.neg_x    <= w_sx[NW-1] ^ r_b2_det[DETW-1];
            r_b3_side.neg_y    <= w_sy[NW-1] ^ r_b2_det[DETW-1];
            r_b3_side.pts      <= r_b2_side.pts;
            r_b3_side.rslt     <= r_b2_side.rslt;
        end
    end

    for (genvar k = 0; k < NW; k++) begin : g_div
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_v[k] <= 1'b0;
                end else if (w_en) begin
                    r_dv_v[k] <= r_b3_v;
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_aqx[k] <= div_step({{DETW{1'b0}}, r_magx}, r_dmag);
                    r_aqy[k] <= div_step({{DETW{1'b0}}, r_magy}, r_dmag);
                    r_dd[k]  <= r_dmag;
                    r_ds[k]  <= r_b3_side;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_v[k] <= 1'b0;
                end else if (w_en) begin
                    r_dv_v[k] <= r_dv_v[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_aqx[k] <= div_step(r_aqx[k-1], r_dd[k-1]);
                    r_aqy[k] <= div_step(r_aqy[k-1], r_dd[k-1]);
                    r_dd[k]  <= r_dd[k-1];
                    r_ds[k]  <= r_ds[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qx     <= r_ds[NW-1].neg_x ? -t_q'({1'b0, r_aqx[NW-1][NW-1:0]})
                                         :  t_q'({1'b0, r_aqx[NW-1][NW-1:0]});
            r_qy     <= r_ds[NW-1].neg_y ? -t_q'({1'b0, r_aqy[NW-1][NW-1:0]})
                                         :  t_q'({1'b0, r_aqy[NW-1][NW-1:0]});
            r_s_side <= r_ds[NW-1];
        end
    end

    assign w_on1 = on_seg(r_qx, r_qy,
                          r_s_side.pts.first_start_x, r_s_side.pts.first_start_y,
                          r_s_side.pts.first_end_x, r_s_side.pts.first_end_y);
    assign w_on2 = on_seg(r_qx, r_qy,
                          r_s_side.pts.second_start_x, r_s_side.pts.second_start_y,
                          r_s_side.pts.second_end_x, r_s_side.pts.second_end_y);

    always_comb begin
        n_o = '0;
        if (!r_s_side.is_cross) begin
            n_o = r_s_side.rslt;
        end else if (w_on1 && w_on2) begin
            n_o.status  = STAT_CROSS;
            n_o.cross_x = r_qx[FIX_BITS-1:0];
            n_o.cross_y = r_qy[FIX_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o <= n_o;
        end
    end

    assign o_res.valid = r_o_v;
    assign o_res.data  = r_o;

endmodule

// ----- bench/seg_checker.sv -----
`timescale 1ns / 1ps
module seg_checker import spi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spi_in_if.sink    i_seg,
    spi_out_if.sink   i_res,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_cross_seen,
    output int        o_overlap_seen
);

    t_result expected_q[$];

    function automatic logic signed [127:0] fix_point(logic signed [127:0] num,
                                                       logic signed [127:0] den);
        logic signed [127:0] q;
        q = (num <<< FRAC_BITS) / den;
        return q;
    endfunction

    function automatic bit in_range(logic signed [127:0] p, longint e1, longint e2);
        logic signed [127:0] a, b;
        a = 128'(signed'(e1)) <<< FRAC_BITS;
        b = 128'(signed'(e2)) <<< FRAC_BITS;
        return (a <= p && p <= b) || (b <= p && p <= a);
    endfunction

    function automatic bit on_segment(longint sx, longint sy, longint ex, longint ey,
                                      logic signed [127:0] px, logic signed [127:0] py);
        if (sx == ex)
            return in_range(py, sy, ey);
        return in_range(px, sx, ex);
    endfunction

    function automatic longint turn(longint ox, longint oy, longint ax, longint ay,
                                    longint bx, longint by);
        return (ax - ox) * (by - oy) - (ay - oy) * (bx - ox);
    endfunction

    function automatic t_result predict(t_seg_pair s);
        t_result r;
        longint p[8];
        longint a1, b1, c1, a2, b2, c2, det;
        logic signed [127:0] dx, dy, px, py;
        int ord[4];
        int rank;
        bit lt;
        p[0] = longint'(s.first_start_x);  p[1] = longint'(s.first_start_y);
        p[2] = longint'(s.first_end_x);    p[3] = longint'(s.first_end_y);
        p[4] = longint'(s.second_start_x); p[5] = longint'(s.second_start_y);
        p[6] = longint'(s.second_end_x);   p[7] = longint'(s.second_end_y);
        r = '0;
        a1 = p[3] - p[1]; b1 = p[0] - p[2];
        c1 = p[1] * (p[2] - p[0]) - p[0] * (p[3] - p[1]);
        a2 = p[7] - p[5]; b2 = p[4] - p[6];
        c2 = p[5] * (p[6] - p[4]) - p[4] * (p[7] - p[5]);
        det = a1 * b2 - a2 * b1;
        if (det != 0) begin
            dx = 128'(signed'(c2)) * b1 - 128'(signed'(c1)) * b2;
            dy = 128'(signed'(a2)) * c1 - 128'(signed'(a1)) * c2;
            px = fix_point(dx, 128'(signed'(det)));
            py = fix_point(dy, 128'(signed'(det)));
            if (on_segment(p[0], p[1], p[2], p[3], px, py)
                    && on_segment(p[4], p[5], p[6], p[7], px, py)) begin
                r.status  = STAT_CROSS;
                r.cross_x = px[31:0];
                r.cross_y = py[31:0];
            end
            return r;
        end
        if (turn(p[0], p[1], p[2], p[3], p[4], p[5]) == 0
                && turn(p[0], p[1], p[2], p[3], p[6], p[7]) == 0
                && turn(p[4], p[5], p[6], p[7], p[0], p[1]) == 0) begin
            for (int i = 0; i < 4; i++) begin
                rank = 0;
                for (int j = 0; j < 4; j++) begin
                    if (j == i) continue;
                    if (p[2*j] != p[2*i]) lt = p[2*j] < p[2*i];
                    else if (p[2*j+1] != p[2*i+1]) lt = p[2*j+1] < p[2*i+1];
                    else lt = j < i;
                    if (lt) rank++;
                end
                ord[rank] = i;
            end
            if ((ord[0] >> 1) != (ord[1] >> 1)) begin
                r.status          = STAT_OVERLAP;
                r.overlap_start_x = t_coord'(p[2*ord[1]]);
                r.overlap_start_y = t_coord'(p[2*ord[1]+1]);
                r.overlap_end_x   = t_coord'(p[2*ord[2]]);
                r.overlap_end_y   = t_coord'(p[2*ord[2]+1]);
            end
        end
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_result want, got;
        if (!i_rst_n) begin
            o_fail_count   <= 0;
            o_cross_seen   <= 0;
            o_overlap_seen <= 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                if (expected_q.size() == 0) begin
                    $error("result with nothing expected: %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.status == STAT_CROSS) o_cross_seen <= o_cross_seen + 1;
                    if (want.status == STAT_OVERLAP) o_overlap_seen <= o_overlap_seen + 1;
                    if (got !== want) begin
                        o_fail_count <= o_fail_count + 1;
                        if (got.status !== want.status)
                            $error("status: expected %0d, got %0d", want.status, got.status);
                        if (got.cross_x !== want.cross_x)
                            $error("cross_x: expected %0d, got %0d", want.cross_x, got.cross_x);
                        if (got.cross_y !== want.cross_y)
                            $error("cross_y: expected %0d, got %0d", want.cross_y, got.cross_y);
                        if (got.overlap_start_x !== want.overlap_start_x)
                            $error("overlap_start_x: expected %0d, got %0d",
                                   want.overlap_start_x, got.overlap_start_x);
                        if (got.overlap_start_y !== want.overlap_start_y)
                            $error("overlap_start_y: expected %0d, got %0d",
                                   want.overlap_start_y, got.overlap_start_y);
                        if (got.overlap_end_x !== want.overlap_end_x)
                            $error("overlap_end_x: expected %0d, got %0d",
                                   want.overlap_end_x, got.overlap_end_x);
                        if (got.overlap_end_y !== want.overlap_end_y)
                            $error("overlap_end_y: expected %0d, got %0d",
                                   want.overlap_end_y, got.overlap_end_y);
                    end
                end
            end
            if (i_seg.valid && i_seg.ready)
                expected_q.insert(expected_q.size(), predict(i_seg.data));
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import spi_pkg::*;

    localparam int LATENCY = 8 + 3 * COORD_BITS + 4 + FRAC_BITS;
    localparam int N_RANDOM = 1600;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, cross_seen, overlap_seen;
    int   sent;

    spi_in_if  seg_ch ();
    spi_out_if res_ch ();

    segment_pair_intersection dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_ch.sink),
        .o_res   (res_ch.source)
    );

    seg_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seg          (seg_ch.sink),
        .i_res          (res_ch.sink),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_cross_seen   (cross_seen),
        .o_overlap_seen (overlap_seen)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: alternate free-running stretches with random stall patterns.
    initial begin
        int mode, len;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 120);
            repeat (len) begin
                @(posedge i_clk);
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: res_ch.ready <= 1'b0;
                endcase
            end
        end
    end

    function automatic t_coord pick_coord();
        case ($urandom_range(0, 5))
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7FFF);
            2: return t_coord'(32'($urandom_range(0, 40)) - 20);
            default: return t_coord'(32'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // Points along a common line give the collinear and touching cases.
    function automatic t_seg_pair pick_pair();
        t_seg_pair s;
        int ox, oy, dx, dy, k[4];
        s = {pick_coord(), pick_coord(), pick_coord(), pick_coord(),
             pick_coord(), pick_coord(), pick_coord(), pick_coord()};
        case ($urandom_range(0, 9))
            0, 1: begin
                ox = $urandom_range(0, 400) - 200; oy = $urandom_range(0, 400) - 200;
                dx = $urandom_range(0, 6) - 3;     dy = $urandom_range(0, 6) - 3;
                foreach (k[i]) k[i] = $urandom_range(0, 12) - 6;
                s = {t_coord'(ox + k[0]*dx), t_coord'(oy + k[0]*dy),
                     t_coord'(ox + k[1]*dx), t_coord'(oy + k[1]*dy),
                     t_coord'(ox + k[2]*dx), t_coord'(oy + k[2]*dy),
                     t_coord'(ox + k[3]*dx), t_coord'(oy + k[3]*dy)};
                // shift the second segment off the line now and then
                if ($urandom_range(0, 3) == 0) s.second_start_y = s.second_start_y + 16'sd1;
                if ($urandom_range(0, 3) == 0)
                    s.second_end_y = t_coord'(int'(s.second_start_y) + k[3]*dy);
            end
            2: begin
                s.second_start_x = s.first_start_x;
                s.second_end_x   = s.first_start_x;
                s.first_end_x    = s.first_start_x;
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic send_pair(input t_seg_pair s);
        seg_ch.valid <= 1'b1;
        seg_ch.data  <= s;
        @(posedge i_clk);
        while (!seg_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            seg_ch.valid <= 1'b0;
            seg_ch.data  <= t_seg_pair'({$urandom, $urandom, $urandom, $urandom});
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin
        t_seg_pair directed[$];
        int burst;
        sent = 0;
        seg_ch.valid <= 1'b0;
        seg_ch.data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.insert(directed.size(),
            {16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd0, 16'sd10, 16'sd10, 16'sd0});
        directed.insert(directed.size(),
            {16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd2, 16'sd3});
        directed.insert(directed.size(),
            {16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd5, 16'sd0, 16'sd20, 16'sd0});
        directed.insert(directed.size(),
            {16'sd0, 16'sd0, 16'sd5, 16'sd0, 16'sd5, 16'sd0, 16'sd9, 16'sd0});
        directed.insert(directed.size(),
            {16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd1, 16'sd10, 16'sd1});
        directed.insert(directed.size(),
            {16'sd3, -16'sd5, 16'sd3, 16'sd5, -16'sd4, 16'sd9, 16'sd8, 16'sd9});
        directed.insert(directed.size(),
            {16'sd3, -16'sd5, 16'sd3, 16'sd5, -16'sd4, 16'sd2, 16'sd8, 16'sd1});
        directed.insert(directed.size(),
            {16'sd2, 16'sd2, 16'sd2, 16'sd2, 16'sd0, 16'sd0, 16'sd4, 16'sd4});
        directed.insert(directed.size(),
            {16'sd2, 16'sd2, 16'sd2, 16'sd2, 16'sd2, 16'sd2, 16'sd2, 16'sd2});
        directed.insert(directed.size(),
            {16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd1, 16'sd0, 16'sd2, 16'sd0});
        directed.insert(directed.size(),
            {-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
             -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768});
        directed.insert(directed.size(),
            {-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768,
             -16'sd32768, -16'sd32768, 16'sd32767, -16'sd32767});
        directed.insert(directed.size(),
            {16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768,
             -16'sd32768, 16'sd0, 16'sd32767, 16'sd1});
        directed.insert(directed.size(),
            {16'sd0, 16'sd0, 16'sd7, 16'sd3, 16'sd1, 16'sd5, 16'sd6, -16'sd2});
        directed.insert(directed.size(),
            {16'sd0, 16'sd0, -16'sd7, 16'sd3, -16'sd1, 16'sd5, -16'sd6, -16'sd2});
        directed.insert(directed.size(),
            {16'sd10, 16'sd10, 16'sd0, 16'sd0, 16'sd5, 16'sd5, 16'sd15, 16'sd15});
        directed.insert(directed.size(),
            {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
             16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        foreach (directed[i]) send_pair(directed[i]);
        idle_gap(1);

        // hold off until the pipeline and queue have drained completely
        while (pending != 0) @(posedge i_clk);

        while (sent < directed.size() + N_RANDOM) begin
            burst = $urandom_range(1, 40);
            repeat (burst) send_pair(pick_pair());
            idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
        end
        idle_gap(1);

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("covered %0d segment pairs: %0d crossing points, %0d overlaps",
                 sent, cross_seen, overlap_seen);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
src/spi_pkg.sv
src/spi_if.sv
src/spi_front.sv
src/spi_fifo.sv
src/spi_back.sv
src/segment_pair_intersection.sv
bench/seg_checker.sv
bench/tb_top.sv
